// ===== rtl/core/nfassm_pkg.sv =====
// Shared types and constants of the NFA state-set matcher.
// Used by the top level; depends on nothing.
package nfassm_pkg;

    localparam int NUM_STATES_DEF = 64;

    localparam int IDX_W   = 6;
    localparam int LABEL_W = 8;
    localparam int EPS_W   = 64;
    localparam int REQ_W   = 2;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_BEGIN  = 2'd1,
        REQ_SYMBOL = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_CLOSE,
        ST_FINISH
    } t_state;

endpackage

// ===== rtl/core/nfa_state_set_matcher.sv =====
// Top level of the NFA state-set matcher: request decode, scan sequencer,
// active-set registers and result register. Depends on nfassm_pkg and nfassm_ram.
// Holds two nfassm_ram instances for the per-state edge and epsilon tables.

// A load request writes one state's table entry. A begin request closes the
// start state over epsilon edges; a symbol request first scans all NUM_STATES
// states through the edge table, one table read a cycle, and then runs the
// same closure. The closure walks a state index around the epsilon table,
// reading the entry of each pending state and expanding each newly reached
// state once; it ends when no state is left to expand. A state reached only
// after the index has passed it waits for a later pass around the table.
// Once the output register is free, the result moves into it. The block
// takes a new request only when it is idle; a finished result may wait in
// the output register while the next request is accepted. There is no
// clearing pass after reset: per-state valid bits make unwritten entries
// read as empty.
module nfa_state_set_matcher #(
    parameter int NUM_STATES = nfassm_pkg::NUM_STATES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration: start state index.
    input  logic                               i_cfg_we,
    input  logic [nfassm_pkg::IDX_W-1:0]       i_cfg_wdata,
    // Request stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata, from bit 0 up: entry_index[5:0], has_edge[6], edge_label[14:7],
    // edge_target[20:15], eps_targets[84:21], is_accepting[85], symbol[93:86],
    // zero fill[95:94].
    input  logic [nfassm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser, from bit 0 up: req_type[1:0].
    input  logic [nfassm_pkg::REQ_W-1:0]       s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata, from bit 0 up: matched[0], alive[1], zero fill[7:2].
    output logic [nfassm_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    import nfassm_pkg::*;

    localparam int AW      = $clog2(NUM_STATES);
    localparam int LT_W    = IDX_W + LABEL_W;
    localparam logic [IDX_W:0]   IDX_LIM = (IDX_W+1)'(NUM_STATES);
    localparam logic [AW-1:0]    LAST    = AW'(NUM_STATES - 1);
    localparam logic [NUM_STATES-1:0] ONE = {{(NUM_STATES-1){1'b0}}, 1'b1};

    // Request field unpacking.
    logic [IDX_W-1:0]   w_entry_index;
    logic               w_has_edge;
    logic [LABEL_W-1:0] w_edge_label;
    logic [IDX_W-1:0]   w_edge_target;
    logic [EPS_W-1:0]   w_eps_targets;
    logic               w_is_accepting;
    logic [LABEL_W-1:0] w_symbol;
    t_req               w_req;

    assign w_entry_index  = s_axis_tdata[5:0];
    assign w_has_edge     = s_axis_tdata[6];
    assign w_edge_label   = s_axis_tdata[14:7];
    assign w_edge_target  = s_axis_tdata[20:15];
    assign w_eps_targets  = s_axis_tdata[84:21];
    assign w_is_accepting = s_axis_tdata[85];
    assign w_symbol       = s_axis_tdata[93:86];
    assign w_req          = t_req'(s_axis_tuser);

    // Registers.
    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_start;
    logic [NUM_STATES-1:0] r_edge_vld;
    logic [NUM_STATES-1:0] r_eps_vld;
    logic [NUM_STATES-1:0] r_acc_mask;
    logic [NUM_STATES-1:0] r_set, n_set;
    logic [NUM_STATES-1:0] r_pend, n_pend;
    logic [NUM_STATES-1:0] r_move, n_move;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_rd_idx;
    logic                  r_rd_vld, n_rd_vld;
    logic                  r_scan_done, n_scan_done;
    logic [LABEL_W-1:0]    r_sym, n_sym;
    logic                  r_out_vld;
    logic                  r_matched;
    logic                  r_alive;

    // Handshake and table control.
    logic                  w_in_fire;
    logic                  w_idx_ok;
    logic                  w_load;
    logic                  w_out_free;
    logic                  w_ram_we;

    // Table read data.
    logic [LT_W-1:0]       w_lt_rdata;
    logic [NUM_STATES-1:0] w_eps_rdata;

    // Scan datapath.
    logic [NUM_STATES-1:0] w_start_bit;
    logic [NUM_STATES-1:0] w_idx_bit;
    logic [NUM_STATES-1:0] w_tgt_bit;
    logic [NUM_STATES-1:0] w_eps;
    logic [IDX_W-1:0]      w_rd_target;
    logic [LABEL_W-1:0]    w_rd_label;
    logic                  w_edge_hit;
    logic                  w_issue;
    logic [AW-1:0]         w_idx_next;

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_idx_ok   = {1'b0, w_entry_index} < IDX_LIM;
    assign w_load     = w_in_fire && (w_req == REQ_LOAD) && w_idx_ok;
    assign w_out_free = !r_out_vld || m_axis_tready;

    // A start state beyond the table leaves the set empty.
    assign w_start_bit = ({1'b0, r_start} < IDX_LIM) ? (ONE << r_start[AW-1:0]) : '0;

    assign w_idx_bit  = ONE << r_idx;
    assign w_idx_next = (r_idx == LAST) ? '0 : r_idx + 1'b1;

    // Edge table returns one state's label and target in the cycle after the read.
    assign w_rd_label  = w_lt_rdata[LABEL_W-1:0];
    assign w_rd_target = w_lt_rdata[LT_W-1:LABEL_W];
    assign w_edge_hit  = r_set[r_rd_idx] && r_edge_vld[r_rd_idx] && (w_rd_label == r_sym);
    assign w_tgt_bit   = ({1'b0, w_rd_target} < IDX_LIM) ?
                         (ONE << w_rd_target[AW-1:0]) : '0;

    // Epsilon successors of the state read last cycle; an unwritten entry is empty.
    assign w_eps   = (r_rd_vld && r_eps_vld[r_rd_idx]) ? w_eps_rdata : '0;
    assign w_issue = r_pend[r_idx];

    nfassm_ram #(
        .WIDTH (LT_W),
        .DEPTH (NUM_STATES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_entry_index[AW-1:0]),
        .i_wdata ({w_edge_target, w_edge_label}),
        .i_raddr (r_idx),
        .o_rdata (w_lt_rdata)
    );

    nfassm_ram #(
        .WIDTH (NUM_STATES),
        .DEPTH (NUM_STATES)
    ) u_eps_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_entry_index[AW-1:0]),
        .i_wdata (w_eps_targets[NUM_STATES-1:0]),
        .i_raddr (r_idx),
        .o_rdata (w_eps_rdata)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    case (w_req)
                        REQ_BEGIN:  n_state = ST_CLOSE;
                        REQ_SYMBOL: n_state = ST_MOVE;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MOVE: begin
                if (r_scan_done && !r_rd_vld) begin
                    n_state = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if ((r_pend == '0) && !r_rd_vld) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        w_ram_we      = w_load;
    end

    // Scan datapath next values.
    always_comb begin
        n_set       = r_set;
        n_pend      = r_pend;
        n_move      = r_move;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_scan_done = r_scan_done;
        n_sym       = r_sym;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    case (w_req)
                        REQ_BEGIN: begin
                            n_set  = w_start_bit;
                            n_pend = w_start_bit;
                            n_idx  = '0;
                        end
                        REQ_SYMBOL: begin
                            n_move      = '0;
                            n_idx       = '0;
                            n_scan_done = 1'b0;
                            n_sym       = w_symbol;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOVE: begin
                // One state per cycle through the edge table.
                if (!r_scan_done) begin
                    n_rd_vld = 1'b1;
                    n_idx    = w_idx_next;
                    if (r_idx == LAST) begin
                        n_scan_done = 1'b1;
                    end
                end
                if (r_rd_vld && w_edge_hit) begin
                    n_move = r_move | w_tgt_bit;
                end
                if (r_scan_done && !r_rd_vld) begin
                    n_set  = r_move;
                    n_pend = r_move;
                    n_idx  = '0;
                end
            end
            ST_CLOSE: begin
                // Each reached state is expanded once; states reached by the
                // returning read become pending if they are new.
                n_rd_vld = w_issue;
                n_idx    = w_idx_next;
                n_set    = r_set | w_eps;
                n_pend   = (r_pend & ~(w_issue ? w_idx_bit : '0)) | (w_eps & ~r_set);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= '0;
            r_edge_vld  <= '0;
            r_eps_vld   <= '0;
            r_acc_mask  <= '0;
            r_set       <= '0;
            r_pend      <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_scan_done <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_set       <= n_set;
            r_pend      <= n_pend;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_scan_done <= n_scan_done;
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
            if (w_load) begin
                r_edge_vld[w_entry_index[AW-1:0]] <= w_has_edge;
                r_eps_vld[w_entry_index[AW-1:0]]  <= 1'b1;
                r_acc_mask[w_entry_index[AW-1:0]] <= w_is_accepting;
            end
            if ((r_state == ST_FINISH) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_move   <= n_move;
        r_sym    <= n_sym;
        r_rd_idx <= r_idx;
        if ((r_state == ST_FINISH) && w_out_free) begin
            r_matched <= |(r_set & r_acc_mask);
            r_alive   <= |r_set;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(M_TDATA_W-2){1'b0}}, r_alive, r_matched};

endmodule

// ===== rtl/core/nfassm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module nfassm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
